// ===== hw/rtl/oqr_pkg.sv =====
// Shared constants, operation and status codes, types for the ordered queue with removal.
package oqr_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [MODE_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] OP_POP    = 3'd1;
  localparam logic [MODE_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

// ===== hw/rtl/oqr_ram.sv =====
// Simple dual-port entry memory with one write port and one registered read port.
module oqr_ram #(
  parameter int unsigned DEPTH      = oqr_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oqr_pkg::DATA_WIDTH_DEF,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/oqr_ctrl.sv =====
// Operation sequencer: circular head pointer, fill count, scan and compaction over the memory.
module oqr_ctrl #(
  parameter int unsigned DEPTH      = oqr_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oqr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [oqr_pkg::MODE_W-1:0]   in_mode,
  input  logic [oqr_pkg::VALUE_W-1:0]  in_value,
  input  logic [oqr_pkg::INDEX_W-1:0]  in_index,
  output logic                         res_valid,
  input  logic                         res_ready,
  output oqr_pkg::result_t             res,
  output logic                         mem_we,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic [DATA_WIDTH-1:0]        mem_wdata,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr,
  input  logic [DATA_WIDTH-1:0]        mem_rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = AW + 2;

  oqr_pkg::state_t state, state_next;

  logic [CW-1:0]                       count, count_next;
  logic [AW-1:0]                       head, head_next;
  logic [AW-1:0]                       pos, pos_next;
  logic [oqr_pkg::MODE_W-1:0]          mode_q, mode_next;
  logic [DATA_WIDTH-1:0]               word_q, word_next;
  logic [oqr_pkg::INDEX_W-1:0]         idx_q, idx_next;
  logic [oqr_pkg::STATUS_W-1:0]        status_q, status_next;
  logic [oqr_pkg::VALUE_W-1:0]         data_q, data_next;

  logic [OW-1:0] pos_p1;
  logic [OW-1:0] pos_p2;
  logic [OW-1:0] count_w;
  logic          match;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                            input logic [OW-1:0] off);
    logic [OW-1:0] s;
    s = OW'(base) + off;
    if (s >= OW'(DEPTH)) begin
      s = s - OW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign pos_p1  = OW'(pos) + OW'(1);
  assign pos_p2  = OW'(pos) + OW'(2);
  assign count_w = OW'(count);
  assign match   = (mem_rdata == word_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oqr_pkg::S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    mode_q   <= mode_next;
    word_q   <= word_next;
    idx_q    <= idx_next;
    status_q <= status_next;
    data_q   <= data_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    head_next   = head;
    pos_next    = pos;
    mode_next   = mode_q;
    word_next   = word_q;
    idx_next    = idx_q;
    status_next = status_q;
    data_next   = data_q;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_of(head, OW'(pos));
    mem_wdata   = mem_rdata;
    mem_raddr   = addr_of(head, pos_p1);

    unique case (state)
      oqr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_next   = in_mode;
          word_next   = DATA_WIDTH'(in_value);
          idx_next    = in_index;
          status_next = oqr_pkg::ST_OK;
          data_next   = '0;
          state_next  = oqr_pkg::S_EXEC;
        end
      end
      oqr_pkg::S_EXEC: begin
        state_next = oqr_pkg::S_DONE;
        case (mode_q)
          oqr_pkg::OP_PUSH: begin
            if (count_w == OW'(DEPTH)) begin
              status_next = oqr_pkg::ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = addr_of(head, count_w);
              mem_wdata  = word_q;
              count_next = count + CW'(1);
            end
          end
          oqr_pkg::OP_POP: begin
            if (count == '0) begin
              status_next = oqr_pkg::ST_EMPTY;
            end else begin
              mem_raddr  = addr_of(head, '0);
              state_next = oqr_pkg::S_READ;
            end
          end
          oqr_pkg::OP_PEEK: begin
            if ((CW + oqr_pkg::INDEX_W)'(idx_q) >= (CW + oqr_pkg::INDEX_W)'(count)) begin
              status_next = oqr_pkg::ST_RANGE;
            end else begin
              mem_raddr  = addr_of(head, OW'(idx_q));
              state_next = oqr_pkg::S_READ;
            end
          end
          oqr_pkg::OP_REMOVE: begin
            if (count == '0) begin
              status_next = oqr_pkg::ST_NOT_FOUND;
            end else begin
              pos_next   = '0;
              mem_raddr  = addr_of(head, '0);
              state_next = oqr_pkg::S_SCAN;
            end
          end
          oqr_pkg::OP_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      oqr_pkg::S_READ: begin
        data_next  = oqr_pkg::VALUE_W'(mem_rdata);
        state_next = oqr_pkg::S_DONE;
        if (mode_q == oqr_pkg::OP_POP) begin
          head_next  = addr_of(head, OW'(1));
          count_next = count - CW'(1);
        end
      end
      oqr_pkg::S_SCAN: begin
        if (match) begin
          if (pos_p1 == count_w) begin
            count_next = count - CW'(1);
            state_next = oqr_pkg::S_DONE;
          end else begin
            state_next = oqr_pkg::S_SHIFT;
          end
        end else if (pos_p1 == count_w) begin
          status_next = oqr_pkg::ST_NOT_FOUND;
          state_next  = oqr_pkg::S_DONE;
        end else begin
          pos_next = pos + AW'(1);
        end
      end
      oqr_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_raddr = addr_of(head, pos_p2);
        if (pos_p2 == count_w) begin
          count_next = count - CW'(1);
          state_next = oqr_pkg::S_DONE;
        end else begin
          pos_next = pos + AW'(1);
        end
      end
      oqr_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = oqr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = oqr_pkg::S_IDLE;
      end
    endcase
  end

  assign res.status = status_q;
  assign res.data   = data_q;
  assign res.count  = oqr_pkg::COUNT_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= OW'(DEPTH))
    else $error("fill count above capacity");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == oqr_pkg::S_SHIFT && pos_p2 != count_w) |-> (mem_waddr != mem_raddr))
    else $error("compaction write hits the entry being read");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == oqr_pkg::S_DONE && status_q == oqr_pkg::ST_FULL) |-> (count_w == OW'(DEPTH)))
    else $error("full status reported below capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == oqr_pkg::S_SCAN || state == oqr_pkg::S_SHIFT) |-> (pos_p1 <= count_w))
    else $error("scan position beyond fill");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (state == oqr_pkg::S_DONE && !res_ready) |=> (state == oqr_pkg::S_DONE && $stable(count)))
    else $error("pending result changed while stalled");

endmodule

// ===== hw/rtl/ordered_queue_with_removal.sv =====
// Top level of the ordered queue with removal: sequencer, entry memory and output register.
//
//   channel  direction  tdata (low bit up)          tuser
//   s_*      in         value[31:0], index[35:32]   mode[2:0]
//   m_*      out        data_out[31:0], count[36:32] status[2:0]
//
// One operation is in progress at a time; a finished result waits in the output
// register while the next word is taken. Push, clear, unused modes and a refused pop or
// peek go from the execute state straight to the result state, pop and peek via a read
// state, remove via the scan and compaction states, which share the one memory read port.
// Reset clears the sequencer state, fill count, head pointer and output valid; no memory sweep is needed.
// A stall on the output side holds the sequencer in its result state.
module ordered_queue_with_removal #(
  parameter int unsigned DEPTH      = oqr_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oqr_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], index[35:32], zero fill
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_out[31:0], count[36:32], zero fill
  output logic [2:0]  m_tuser    // status[2:0]
);

  localparam int unsigned AW = $clog2(DEPTH);

  oqr_pkg::result_t      res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  oqr_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_value  (s_tdata[31:0]),
    .in_index  (s_tdata[35:32]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  oqr_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, res.count, res.data};
      m_tuser <= res.status;
    end
  end

endmodule
